/* design/cipso_option_tag_parser_core_defines.svh */
// Assertion helpers shared by the CIPSO parser modules.
`ifndef CIPSO_OPTION_TAG_PARSER_CORE_DEFINES_SVH
`define CIPSO_OPTION_TAG_PARSER_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define COTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define COTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/cotp_pkg.sv */
`default_nettype none
package cotp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CAT      = 3'd0,
    KIND_RANGE    = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_NO_CIPSO = 3'd3,
    KIND_SHORT    = 3'd4,
    KIND_DONE     = 3'd5
  } kind_e;

  // Header and option constants
  localparam logic [7:0] CIPSO_TYPE = 8'd134;
  localparam logic [5:0] OPT_BASE   = 6'd20;
  localparam logic [5:0] TAG_FIRST  = 6'd6;
  localparam logic [5:0] TAG_MIN    = 6'd4;

  // Tag types
  localparam logic [7:0] TAG_BITMAP = 8'd1;
  localparam logic [7:0] TAG_ENUM   = 8'd2;
  localparam logic [7:0] TAG_RANGE  = 8'd5;

  // Configuration registers
  localparam logic CFG_MAX_TAGS = 1'b0;
  localparam logic CFG_MAX_OPTS = 1'b1;
  localparam logic [3:0] MAX_TAGS_RST = 4'd10;
  localparam logic [3:0] MAX_OPTS_RST = 4'd4;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Work record: bitmap bits, or one single result, plus end-of-packet mark
  typedef struct packed {
    logic [31:0] domain;
    logic [7:0]  sens;
    logic [7:0]  tk;
    logic [15:0] base;
    logic [7:0]  mask;
    logic        s_valid;
    kind_e       s_kind;
    logic [15:0] s_lo;
    logic [15:0] s_hi;
    logic        fin;
  } rec_t;

endpackage
`default_nettype wire

/* design/cotp_ifs.sv */
`default_nettype none
interface cotp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface cotp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] domain;
  logic [7:0]  tag_kind;
  logic [7:0]  sensitivity;
  logic [15:0] cat_low;
  logic [15:0] cat_high;
  logic        last;
  modport source (output valid, output kind, output domain, output tag_kind,
                  output sensitivity, output cat_low, output cat_high, output last,
                  input ready);
  modport sink (input valid, input kind, input domain, input tag_kind,
                input sensitivity, input cat_low, input cat_high, input last,
                output ready);
endinterface
`default_nettype wire

/* design/cipso_option_tag_parser_core.sv */
// Results go through the queue, a current-record register and the output register.
// Throughput: one header byte per cycle; the back end gives one result per cycle while
//   the output is free, so a bitmap byte with k set bits gives k results, absorbed by
//   a 4-entry queue. Input is stalled only while that queue is full.
// Reset (rst_ni low, asynchronous): parser idle, queue empty, no result pending,
//   max_tags = 10, max_other_options = 4.
`default_nettype none
module cipso_option_tag_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  cotp_in_if.sink         in_ch,
  cotp_out_if.source      out_ch
);

  logic           push, full, pop, empty;
  cotp_pkg::rec_t wr_rec, rd_rec;

  cotp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch, .full_i(full), .push_o(push), .rec_o(wr_rec)
  );

  cotp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(wr_rec), .full_o(full),
    .pop_i(pop), .data_o(rd_rec), .empty_o(empty)
  );

  cotp_back u_back (
    .clk_i, .rst_ni, .head_i(rd_rec), .empty_i(empty), .pop_o(pop), .out_ch
  );

endmodule
`default_nettype wire

/* design/cotp_front.sv */
`default_nettype none
module cotp_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  cotp_in_if.sink          in_ch,
  input  wire logic        full_i,
  output logic             push_o,
  output cotp_pkg::rec_t   rec_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_OPTLEN = 2'd2;
  localparam logic [1:0] PH_CIPSO  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [5:0]  bp_q, bp_d, hdr_q, hdr_d, on_q, on_d;
  logic [3:0]  os_q, os_d, tc_q, tc_d;
  logic [7:0]  clen_q, clen_d, ts_q, ts_d, tk_q, tk_d, tl_q, tl_d, sens_q, sens_d;
  logic [7:0]  bh_q, bh_d;
  logic [15:0] wh_q, wh_d;
  logic [31:0] dom_q, dom_d;
  logic [3:0]  max_tags_q, max_opts_q;

  logic        acc;
  logic [7:0]  b;
  logic [5:0]  bp, rel, t, off;
  logic [7:0]  eff;
  logic [8:0]  nx9;
  logic [3:0]  lim_o, lim_t, tcn;
  logic        rpt;
  cotp_pkg::kind_e rpt_kind;
  cotp_pkg::rec_t  rec;

  assign in_ch.ready = !full_i;
  assign acc   = in_ch.valid && !full_i;
  assign b     = in_ch.data_byte;
  assign lim_o = (max_opts_q == 4'd0) ? 4'd1 : max_opts_q;
  assign lim_t = (max_tags_q == 4'd0) ? 4'd1 : max_tags_q;

  // Parse one byte: next state and the work record it causes
  always_comb begin
    phase_d = phase_q; bp_d = bp_q; hdr_d = hdr_q; on_d = on_q; os_d = os_q;
    tc_d = tc_q; clen_d = clen_q; ts_d = ts_q; tk_d = tk_q; tl_d = tl_q;
    sens_d = sens_q; bh_d = bh_q; wh_d = wh_q; dom_d = dom_q;
    bp = bp_q; rel = '0; t = '0; off = '0; eff = '0; nx9 = '0; tcn = '0;
    rpt = 1'b0; rpt_kind = cotp_pkg::KIND_NO_CIPSO;
    rec = '0;
    rec.s_kind = cotp_pkg::KIND_CAT;
    if (acc) begin
      if (in_ch.first) begin
        bp_d = '0; hdr_d = {b[3:0], 2'b00}; on_d = cotp_pkg::OPT_BASE; os_d = '0;
        clen_d = '0; dom_d = '0; ts_d = {2'b00, cotp_pkg::TAG_FIRST}; tc_d = '0;
        tk_d = '0; tl_d = '0; sens_d = '0; wh_d = '0; bh_d = '0;
        if (hdr_d <= cotp_pkg::OPT_BASE) begin
          rpt = 1'b1;
        end else begin
          phase_d = PH_SEARCH;
        end
      end else if (phase_q != PH_IDLE) begin
        bp = bp_q + 6'd1;
        bp_d = bp;
        unique case (phase_q)
          PH_SEARCH: begin
            if (bp == on_q) begin
              if (b <= 8'd1) on_d = on_q + 6'd1;
              else if (b == cotp_pkg::CIPSO_TYPE) phase_d = PH_CIPSO;
              else phase_d = PH_OPTLEN;
            end
          end
          PH_OPTLEN: begin
            nx9 = {3'b000, on_q} + {1'b0, b};
            if (b < 8'd2) begin
              rpt = 1'b1;
            end else begin
              os_d = os_q + 4'd1;
              if (os_d >= lim_o || os_d == 4'd0 || nx9 >= {3'b000, hdr_q}) begin
                rpt = 1'b1;
              end else begin
                on_d = nx9[5:0];
                phase_d = PH_SEARCH;
              end
            end
          end
          PH_CIPSO: begin
            rel = bp - on_q;
            if (rel == 6'd1) begin
              clen_d = b;
              if (b <= {2'b00, cotp_pkg::TAG_FIRST}) begin
                rpt = 1'b1; rpt_kind = cotp_pkg::KIND_SHORT;
              end
            end else if (rel < cotp_pkg::TAG_FIRST) begin
              dom_d = {dom_q[23:0], b};
            end else if ({2'b00, rel} >= ts_q) begin
              t = rel - ts_q[5:0];
              off = t - cotp_pkg::TAG_MIN;
              // Capture tag head or decode a body byte
              if (t == 6'd0) tk_d = b;
              else if (t == 6'd1) tl_d = b;
              else if (t == 6'd3) sens_d = b;
              else if (t >= cotp_pkg::TAG_MIN) begin
                if (tk_q == cotp_pkg::TAG_BITMAP) begin
                  rec.mask = b;
                  rec.base = {7'b0, off, 3'b000};
                  rec.sens = sens_q;
                end else if (tk_q == cotp_pkg::TAG_ENUM) begin
                  if (!off[0]) begin
                    wh_d = {8'h00, b};
                  end else begin
                    rec.s_valid = 1'b1; rec.s_kind = cotp_pkg::KIND_CAT;
                    rec.tk = cotp_pkg::TAG_ENUM; rec.sens = sens_q;
                    rec.s_lo = {wh_q[7:0], b}; rec.s_hi = {wh_q[7:0], b};
                  end
                end else if (tk_q == cotp_pkg::TAG_RANGE) begin
                  case (off[1:0])
                    2'd0: wh_d = {b, 8'h00};
                    2'd1: wh_d = wh_q | {8'h00, b};
                    2'd2: bh_d = b;
                    default: begin
                      rec.s_valid = 1'b1; rec.s_kind = cotp_pkg::KIND_RANGE;
                      rec.tk = cotp_pkg::TAG_RANGE; rec.sens = sens_q;
                      rec.s_lo = wh_q; rec.s_hi = {bh_q, b};
                    end
                  endcase
                end
              end
              // Close the tag on its last byte
              if (t >= 6'd3) begin
                eff = (tl_q < {2'b00, cotp_pkg::TAG_MIN}) ? {2'b00, cotp_pkg::TAG_MIN} : tl_q;
                if ({2'b00, t} == eff - 8'd1) begin
                  if (tk_q == cotp_pkg::TAG_RANGE) begin
                    if (t >= cotp_pkg::TAG_MIN && (off[1:0] == 2'd1 || off[1:0] == 2'd2)) begin
                      rec.s_valid = 1'b1; rec.s_kind = cotp_pkg::KIND_RANGE;
                      rec.tk = cotp_pkg::TAG_RANGE; rec.sens = sens_q;
                      rec.s_lo = wh_d; rec.s_hi = '0;
                    end
                  end else if (tk_q != cotp_pkg::TAG_BITMAP && tk_q != cotp_pkg::TAG_ENUM) begin
                    rec.s_valid = 1'b1; rec.s_kind = cotp_pkg::KIND_UNKNOWN;
                    rec.tk = tk_q; rec.sens = sens_d; rec.s_lo = '0; rec.s_hi = '0;
                  end
                  tcn = tc_q + 4'd1;
                  tc_d = tcn;
                  nx9 = {1'b0, ts_q} + {1'b0, eff};
                  if (tcn >= lim_t || tcn == 4'd0 || nx9 >= {1'b0, clen_q}) begin
                    rec.fin = 1'b1;
                    phase_d = PH_IDLE;
                  end else begin
                    ts_d = nx9[7:0];
                  end
                end
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
        // End of header with the packet still open
        if (!rpt && phase_d != PH_IDLE && ({1'b0, bp} + 7'd1) >= {1'b0, hdr_q}) begin
          if (phase_d == PH_SEARCH || phase_d == PH_OPTLEN) begin
            rpt = 1'b1;
          end else if ((bp - on_d) < cotp_pkg::TAG_FIRST) begin
            rpt = 1'b1; rpt_kind = cotp_pkg::KIND_SHORT;
          end else begin
            rec.fin = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
    end
    if (rpt) begin
      rec.s_valid = 1'b1; rec.s_kind = rpt_kind; rec.tk = '0; rec.sens = '0;
      rec.s_lo = '0; rec.s_hi = '0; rec.mask = '0; rec.fin = 1'b1;
      phase_d = PH_IDLE;
    end
    rec.domain = dom_d;
  end

  assign rec_o  = rec;
  assign push_o = acc && (rec.mask != 8'h00 || rec.s_valid || rec.fin);

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bp_q <= '0; hdr_q <= '0; on_q <= '0; os_q <= '0;
      tc_q <= '0; clen_q <= '0; ts_q <= {2'b00, cotp_pkg::TAG_FIRST}; tk_q <= '0;
      tl_q <= '0; sens_q <= '0; bh_q <= '0; wh_q <= '0; dom_q <= '0;
    end else begin
      phase_q <= phase_d; bp_q <= bp_d; hdr_q <= hdr_d; on_q <= on_d; os_q <= os_d;
      tc_q <= tc_d; clen_q <= clen_d; ts_q <= ts_d; tk_q <= tk_d; tl_q <= tl_d;
      sens_q <= sens_d; bh_q <= bh_d; wh_q <= wh_d; dom_q <= dom_d;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tags_q <= cotp_pkg::MAX_TAGS_RST;
      max_opts_q <= cotp_pkg::MAX_OPTS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cotp_pkg::CFG_MAX_TAGS) max_tags_q <= cfg_data_i;
      if (cfg_idx_i == cotp_pkg::CFG_MAX_OPTS) max_opts_q <= cfg_data_i;
    end
  end

endmodule
`default_nettype wire

/* design/cotp_fifo.sv */
`default_nettype none
`include "cipso_option_tag_parser_core_defines.svh"
module cotp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cotp_pkg::rec_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output cotp_pkg::rec_t      data_o,
  output logic                empty_o
);

  cotp_pkg::rec_t mem [cotp_pkg::FIFO_DEPTH];
  logic [cotp_pkg::FIFO_AW-1:0] wp_q, rp_q;
  logic [cotp_pkg::FIFO_AW:0]   count_q;

  assign full_o  = count_q == (cotp_pkg::FIFO_AW+1)'(cotp_pkg::FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem[rp_q];

  // Store records
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wp_q] <= data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; count_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  `COTP_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `COTP_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")
  `COTP_ASSERT_ALWAYS(a_count_bound, count_q <= (cotp_pkg::FIFO_AW+1)'(cotp_pkg::FIFO_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

/* design/cotp_back.sv */
`default_nettype none
`include "cipso_option_tag_parser_core_defines.svh"
module cotp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cotp_pkg::rec_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  cotp_out_if.source          out_ch
);

  cotp_pkg::rec_t  cur_q;
  logic            cur_valid_q;
  logic            out_valid_q;
  cotp_pkg::kind_e out_kind_q;
  logic [31:0]     out_dom_q;
  logic [7:0]      out_tk_q, out_sens_q;
  logic [15:0]     out_lo_q, out_hi_q;
  logic            out_last_q;

  logic            free, fire, done, found, last;
  logic [2:0]      idx;
  logic [7:0]      mask_rest;
  cotp_pkg::kind_e kind;
  logic [7:0]      tk, sens;
  logic [15:0]     lo, hi;

  assign free  = !out_valid_q || out_ch.ready;
  assign fire  = cur_valid_q && free;
  assign pop_o = (!cur_valid_q || (fire && done)) && !empty_i;

  // Pick the next result of the current record
  always_comb begin
    found = 1'b0; idx = '0; mask_rest = cur_q.mask; done = 1'b0; last = 1'b0;
    kind = cotp_pkg::KIND_DONE; tk = '0; sens = '0; lo = '0; hi = '0;
    if (cur_q.mask != 8'h00) begin
      for (int i = 0; i < 8; i++) begin
        if (!found && cur_q.mask[3'(7 - i)]) begin
          found = 1'b1;
          idx = 3'(i);
        end
      end
      mask_rest = cur_q.mask & ~(8'h80 >> idx);
      kind = cotp_pkg::KIND_CAT; tk = cotp_pkg::TAG_BITMAP; sens = cur_q.sens;
      lo = cur_q.base + {13'b0, idx}; hi = lo;
      done = (mask_rest == 8'h00) && !cur_q.s_valid;
      last = cur_q.fin && done;
    end else if (cur_q.s_valid) begin
      kind = cur_q.s_kind; tk = cur_q.tk; sens = cur_q.sens;
      lo = cur_q.s_lo; hi = cur_q.s_hi;
      done = 1'b1; last = cur_q.fin;
    end else begin
      done = 1'b1; last = 1'b1;
    end
  end

  // Hold the current record; take the next one when it is drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
    end else if (fire && done) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    else if (fire) cur_q.mask <= mask_rest;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_kind_q <= kind; out_dom_q <= cur_q.domain; out_tk_q <= tk;
      out_sens_q <= sens; out_lo_q <= lo; out_hi_q <= hi; out_last_q <= last;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.kind        = out_kind_q;
  assign out_ch.domain      = out_dom_q;
  assign out_ch.tag_kind    = out_tk_q;
  assign out_ch.sensitivity = out_sens_q;
  assign out_ch.cat_low     = out_lo_q;
  assign out_ch.cat_high    = out_hi_q;
  assign out_ch.last        = out_last_q;

  `COTP_ASSERT(a_done_is_last, out_valid_q && out_kind_q == cotp_pkg::KIND_DONE |-> out_last_q, "done result without last")
  `COTP_ASSERT(a_no_empty_rec, cur_valid_q |-> (cur_q.mask != 8'h00 || cur_q.s_valid || cur_q.fin), "empty record in back end")
  `COTP_ASSERT(a_pop_when_free, pop_o |-> (!cur_valid_q || done), "record replaced before drained")

endmodule
`default_nettype wire
